FILE: rtl/core/md5_pkg.sv
package md5_pkg;

   // one input transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   // one digest word transaction
   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_type;

   // source of the byte written into the block buffer
   typedef enum logic [1:0] {
      SRC_DATA = 2'd0,
      SRC_PAD  = 2'd1,
      SRC_ZERO = 2'd2,
      SRC_LEN  = 2'd3
   } byte_src_type;

   // controller to datapath commands
   typedef struct packed {
      logic         absorb;
      byte_src_type byte_src;
      logic [2:0]   len_sel;
      logic         snap_len;
      logic         load_work;
      logic         round_en;
      logic [5:0]   rd_round;
      logic [5:0]   round;
      logic         add_cv;
      logic         reinit;
      logic [1:0]   out_idx;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [5:0] pos;
   } dp_stat_type;

   localparam logic [7:0]  PAD_BYTE   = 8'h80;
   localparam logic [5:0]  LEN_POS    = 6'd56;
   localparam logic [5:0]  LAST_POS   = 6'h3F;
   localparam logic [5:0]  LAST_ROUND = 6'd63;
   localparam logic [2:0]  LAST_LEN   = 3'd7;
   localparam logic [1:0]  LAST_WORD  = 2'd3;
   localparam logic [63:0] BYTE_BITS  = 64'd8;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   // additive round constants
   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // rotate amount per round
   function automatic logic [4:0] shift_amt(input logic [5:0] rnd);
      logic [4:0] s;
      case (rnd[5:4])
         2'd0: begin
            case (rnd[1:0])
               2'd0:    s = 5'd7;
               2'd1:    s = 5'd12;
               2'd2:    s = 5'd17;
               default: s = 5'd22;
            endcase
         end
         2'd1: begin
            case (rnd[1:0])
               2'd0:    s = 5'd5;
               2'd1:    s = 5'd9;
               2'd2:    s = 5'd14;
               default: s = 5'd20;
            endcase
         end
         2'd2: begin
            case (rnd[1:0])
               2'd0:    s = 5'd4;
               2'd1:    s = 5'd11;
               2'd2:    s = 5'd16;
               default: s = 5'd23;
            endcase
         end
         default: begin
            case (rnd[1:0])
               2'd0:    s = 5'd6;
               2'd1:    s = 5'd10;
               2'd2:    s = 5'd15;
               default: s = 5'd21;
            endcase
         end
      endcase
      return s;
   endfunction

   // message word used by each round
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [7:0] r;
      logic [7:0] t;
      r = {4'd0, rnd[3:0]};
      case (rnd[5:4])
         2'd0:    t = r;
         2'd1:    t = r * 8'd5 + 8'd1;
         2'd2:    t = r * 8'd3 + 8'd5;
         default: t = r * 8'd7;
      endcase
      return t[3:0];
   endfunction

   // nonlinear function per quarter
   function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      case (grp)
         2'd0:    f = (b & c) | (~b & d);
         2'd1:    f = (b & d) | (c & ~d);
         2'd2:    f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
      return f;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] t;
      t = {v, v} << s;
      return t[63:32];
   endfunction

endpackage

FILE: rtl/core/md5_ctrl.sv
module md5_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  md5_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output md5_pkg::ctrl_cmd_type cmd,
   input  md5_pkg::dp_stat_type  stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD80,
      S_ZERO,
      S_LEN,
      S_FETCH,
      S_ROUND,
      S_FINAL,
      S_OUT
   } state_type;

   state_type  state_ff, state_in;
   state_type  resume_ff, resume_in;
   state_type  follow;
   logic [5:0] round_ff, round_in;
   logic [2:0] lenb_ff, lenb_in;
   logic [1:0] oidx_ff, oidx_in;
   logic [5:0] pos_next;
   logic       req_acc;

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = (state_ff == S_OUT);
   assign req_acc   = req_valid && req_ready;
   assign pos_next  = stat.pos + 6'd1;

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      follow    = state_ff;
      round_in  = round_ff;
      lenb_in   = lenb_ff;
      oidx_in   = oidx_ff;
      cmd       = '0;
      cmd.byte_src = md5_pkg::SRC_DATA;
      cmd.len_sel  = lenb_ff;
      cmd.round    = round_ff;
      cmd.rd_round = round_ff;
      cmd.out_idx  = oidx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               cmd.absorb = req_data.byte_valid;
               follow     = req_data.end_of_message ? S_PAD80 : S_IDLE;
            end
         end
         S_PAD80: begin
            cmd.absorb   = 1'b1;
            cmd.byte_src = md5_pkg::SRC_PAD;
            cmd.snap_len = 1'b1;
            lenb_in      = '0;
            follow       = (pos_next == md5_pkg::LEN_POS) ? S_LEN : S_ZERO;
         end
         S_ZERO: begin
            cmd.absorb   = 1'b1;
            cmd.byte_src = md5_pkg::SRC_ZERO;
            follow       = (pos_next == md5_pkg::LEN_POS) ? S_LEN : S_ZERO;
         end
         S_LEN: begin
            cmd.absorb   = 1'b1;
            cmd.byte_src = md5_pkg::SRC_LEN;
            lenb_in      = lenb_ff + 3'd1;
            follow       = (lenb_ff == md5_pkg::LAST_LEN) ? S_OUT : S_LEN;
         end
         S_FETCH: begin
            cmd.load_work = 1'b1;
            cmd.rd_round  = '0;
            round_in      = '0;
            state_in      = S_ROUND;
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            cmd.rd_round = round_ff + 6'd1;
            round_in     = round_ff + 6'd1;
            if (round_ff == md5_pkg::LAST_ROUND) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            cmd.add_cv = 1'b1;
            state_in   = resume_ff;
         end
         S_OUT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 2'd1;
               if (oidx_ff == md5_pkg::LAST_WORD) begin
                  cmd.reinit = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // a byte landing in the last slot triggers a block compression
      if (state_ff == S_IDLE || state_ff == S_PAD80 || state_ff == S_ZERO ||
          state_ff == S_LEN) begin
         if (cmd.absorb && stat.pos == md5_pkg::LAST_POS) begin
            state_in  = S_FETCH;
            resume_in = follow;
         end else begin
            state_in = follow;
         end
      end
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         resume_ff <= S_IDLE;
         round_ff  <= '0;
         lenb_ff   <= '0;
         oidx_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
         round_ff  <= round_in;
         lenb_ff   <= lenb_in;
         oidx_ff   <= oidx_in;
      end
   end

   // never both sides open at once
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result channels open together");

   // digest words go out in order without a gap
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && oidx_ff != md5_pkg::LAST_WORD
      |=> rsp_valid && oidx_ff == $past(oidx_ff) + 2'd1)
      else $error("digest word sequence broken");

   // the last round is always followed by the chaining add
   a_final_add: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROUND && round_ff == md5_pkg::LAST_ROUND |=> state_ff == S_FINAL)
      else $error("compression did not end with the chaining add");

endmodule

FILE: rtl/core/md5_dpath.sv
module md5_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            data_byte,
   input  md5_pkg::ctrl_cmd_type cmd,
   output md5_pkg::dp_stat_type  stat,
   output logic [31:0]           digest_word
);

   logic [31:0] buf_mem [16];
   logic [31:0] w_ff;
   logic [31:0] cv_ff [4];
   logic [63:0] bit_len_ff;
   logic [63:0] len_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [7:0]  wr_byte;
   logic [5:0]  pos;
   logic [31:0] sum;
   logic [31:0] b_in;

   assign pos         = bit_len_ff[8:3];
   assign stat.pos    = pos;
   assign digest_word = cv_ff[cmd.out_idx];

   // byte written into the block buffer
   always_comb begin
      case (cmd.byte_src)
         md5_pkg::SRC_DATA: wr_byte = data_byte;
         md5_pkg::SRC_PAD:  wr_byte = md5_pkg::PAD_BYTE;
         md5_pkg::SRC_ZERO: wr_byte = '0;
         md5_pkg::SRC_LEN:  wr_byte = len_ff[{cmd.len_sel, 3'b000} +: 8];
         default:           wr_byte = '0;
      endcase
   end

   // block buffer, byte writes into little-endian words
   always_ff @(posedge clock) begin
      if (cmd.absorb) begin
         buf_mem[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= wr_byte;
      end
      w_ff <= buf_mem[md5_pkg::msg_index(cmd.rd_round)];
   end

   // one round step
   always_comb begin
      sum  = a_ff + md5_pkg::round_f(cmd.round[5:4], b_ff, c_ff, d_ff)
           + md5_pkg::ROUND_K[cmd.round] + w_ff;
      b_in = b_ff + md5_pkg::rotl32(sum, md5_pkg::shift_amt(cmd.round));
   end

   // working variables
   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         a_ff <= cv_ff[0];
         b_ff <= cv_ff[1];
         c_ff <= cv_ff[2];
         d_ff <= cv_ff[3];
      end else if (cmd.round_en) begin
         a_ff <= d_ff;
         b_ff <= b_in;
         c_ff <= b_ff;
         d_ff <= c_ff;
      end
   end

   // message length snapshot for padding
   always_ff @(posedge clock) begin
      if (cmd.snap_len) begin
         len_ff <= bit_len_ff;
      end
   end

   // chaining value and bit count
   always_ff @(posedge clock) begin
      if (reset || cmd.reinit) begin
         cv_ff[0]   <= md5_pkg::IV_A;
         cv_ff[1]   <= md5_pkg::IV_B;
         cv_ff[2]   <= md5_pkg::IV_C;
         cv_ff[3]   <= md5_pkg::IV_D;
         bit_len_ff <= '0;
      end else begin
         if (cmd.add_cv) begin
            cv_ff[0] <= cv_ff[0] + a_ff;
            cv_ff[1] <= cv_ff[1] + b_ff;
            cv_ff[2] <= cv_ff[2] + c_ff;
            cv_ff[3] <= cv_ff[3] + d_ff;
         end
         if (cmd.absorb) begin
            bit_len_ff <= bit_len_ff + md5_pkg::BYTE_BITS;
         end
      end
   end

   // every absorbed byte moves the count by one byte
   a_len_step: assert property (@(posedge clock) disable iff (reset)
      cmd.absorb |=> bit_len_ff == $past(bit_len_ff) + md5_pkg::BYTE_BITS)
      else $error("bit count did not advance by one byte");

endmodule

FILE: rtl/core/md5_message_digest.sv
// channel   ports                              payload
// input     req_valid  req_ready  req_data     data_byte, byte_valid, end_of_message
// result    rsp_valid  rsp_ready  rsp_data     digest_word, word_index, last_word
//
// a byte that does not fill a block is absorbed without holding off the input
// the 64th byte of a block starts a compression: word fetch, 64 rounds of the
// single round unit, chaining add
// end of message writes each padding and length byte in turn, plus one compression per block
// filled, then the four digest words; input is held off until the last is taken
// reset is synchronous and restores the initial chaining value and a zero count
module md5_message_digest (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  md5_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output md5_pkg::rsp_type rsp_data
);

   md5_pkg::ctrl_cmd_type cmd;
   md5_pkg::dp_stat_type  stat;
   logic [31:0]           digest_word;

   md5_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   md5_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_data.data_byte),
      .cmd         (cmd),
      .stat        (stat),
      .digest_word (digest_word)
   );

   // result transaction
   always_comb begin
      rsp_data.digest_word = digest_word;
      rsp_data.word_index  = cmd.out_idx;
      rsp_data.last_word   = (cmd.out_idx == md5_pkg::LAST_WORD);
   end

endmodule

FILE: tb/md5_message_digest_check.sv
`timescale 1ns / 1ps

module md5_message_digest_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  md5_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  md5_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);

   localparam logic [31:0] START_A     = 32'h67452301;
   localparam logic [31:0] START_B     = 32'hefcdab89;
   localparam logic [31:0] START_C     = 32'h98badcfe;
   localparam logic [31:0] START_D     = 32'h10325476;
   localparam logic [7:0]  MARK_BYTE   = 8'h80;
   localparam logic [5:0]  LENGTH_SLOT = 6'd56;
   localparam logic [5:0]  BLOCK_END   = 6'd63;
   localparam int          FINAL_WORD  = 3;

   // rotate amounts, four per quarter
   localparam int ROT_BY [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   // additive sine constants
   localparam logic [31:0] ADD_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // predicted digest state
   logic [31:0]      chain_word [4];
   logic [63:0]      msg_bits;
   logic [7:0]       block_bytes [64];
   md5_pkg::rsp_type expected_words [$];
   md5_pkg::rsp_type want;
   logic             bad;

   function automatic logic [31:0] rot_left(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   // sixty-four rounds over the buffered block, then the chaining add
   task automatic mix_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t;
      int          k;
      int          r;
      for (r = 0; r < 16; r++) begin
         w[r] = {block_bytes[4 * r + 3], block_bytes[4 * r + 2],
                 block_bytes[4 * r + 1], block_bytes[4 * r]};
      end
      a = chain_word[0];
      b = chain_word[1];
      c = chain_word[2];
      d = chain_word[3];
      for (r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin
               f = (b & c) | (~b & d);
               k = r;
            end
            1: begin
               f = (b & d) | (c & ~d);
               k = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               k = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               k = (7 * r) % 16;
            end
         endcase
         t = d;
         d = c;
         c = b;
         b = b + rot_left(a + f + ADD_K[r] + w[k], ROT_BY[(r / 16) * 4 + r % 4]);
         a = t;
      end
      chain_word[0] = chain_word[0] + a;
      chain_word[1] = chain_word[1] + b;
      chain_word[2] = chain_word[2] + c;
      chain_word[3] = chain_word[3] + d;
   endtask

   task automatic take_byte(input logic [7:0] v);
      logic [5:0] slot;
      slot = msg_bits[8:3];
      block_bytes[slot] = v;
      msg_bits = msg_bits + 64'd8;
      if (slot == BLOCK_END) begin
         mix_block();
      end
   endtask

   task automatic restart_message();
      chain_word[0] = START_A;
      chain_word[1] = START_B;
      chain_word[2] = START_C;
      chain_word[3] = START_D;
      msg_bits = '0;
   endtask

   // padding, length, then the four digest words
   task automatic close_message();
      logic [63:0]      len;
      md5_pkg::rsp_type word;
      int               i;
      len = msg_bits;
      take_byte(MARK_BYTE);
      while (msg_bits[8:3] != LENGTH_SLOT) begin
         take_byte(8'h00);
      end
      for (i = 0; i < 8; i++) begin
         take_byte(len[8 * i +: 8]);
      end
      for (i = 0; i < 4; i++) begin
         word.digest_word = chain_word[i];
         word.word_index  = i[1:0];
         word.last_word   = (i == FINAL_WORD);
         expected_words.push_back(word);
      end
      restart_message();
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
      foreach (block_bytes[i]) begin
         block_bytes[i] = 8'h00;
      end
   end

   // predict on each input transaction, compare on each result transaction
   always @(posedge clock) begin
      if (reset) begin
         restart_message();
         expected_words.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_data.byte_valid) begin
               take_byte(req_data.data_byte);
            end
            if (req_data.end_of_message) begin
               close_message();
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected digest word: expected none, actual %h index %0d last %0b",
                        $time, rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               bad  = 1'b0;
               if (rsp_data.digest_word !== want.digest_word) begin
                  $display("%0t: digest_word: expected %h, actual %h",
                           $time, want.digest_word, rsp_data.digest_word);
                  bad = 1'b1;
               end
               if (rsp_data.word_index !== want.word_index) begin
                  $display("%0t: word_index: expected %0d, actual %0d",
                           $time, want.word_index, rsp_data.word_index);
                  bad = 1'b1;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $display("%0t: last_word: expected %0b, actual %0b",
                           $time, want.last_word, rsp_data.last_word);
                  bad = 1'b1;
               end
               if (bad) begin
                  fail_count++;
               end
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

FILE: tb/md5_message_digest_test.sv
`timescale 1ns / 1ps

module md5_message_digest_test;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int ITEM_TARGET   = 380;
   localparam int QUIET_FROM    = 310;
   localparam int PAUSE_AT      = 160;
   localparam int GAP_MAX       = 14;
   localparam int HOLD_CYCLES   = 500;
   localparam int STALL_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 80;
   localparam int DRAIN_CYCLES  = 100;

   // message lengths around the padding and block boundaries
   localparam int EDGE_LENGTHS [10] = '{0, 55, 56, 57, 63, 64, 65, 119, 120, 128};

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   md5_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   md5_pkg::rsp_type rsp_data;

   int fail_count;
   int pending;
   int items_sent   = 0;
   bit quiet        = 1'b0;
   bit sender_idle  = 1'b0;
   bit hold_request = 1'b0;
   bit paused       = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   md5_message_digest dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   md5_message_digest_check digest_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // one input transaction, with an optional idle burst ahead of it
   task automatic send_item(input logic [7:0] value, input logic has_byte, input logic ends);
      int gap;
      gap = 0;
      if (sender_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, GAP_MAX);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{data_byte: value, byte_valid: has_byte, end_of_message: ends};
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // random bytes, stray empty transactions, end mark on the last byte or alone
   task automatic send_message(input int len);
      logic end_on_byte;
      int   i;
      end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte) begin
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
   endtask

   function automatic int pick_length();
      case ($urandom_range(0, 5))
         0, 1:    return EDGE_LENGTHS[$urandom_range(0, 9)];
         2:       return $urandom_range(0, 3);
         default: return $urandom_range(1, 24);
      endcase
   endfunction

   // stop offering until every digest word is in, then let the block settle
   task automatic drain_results(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // result side: ready and stall bursts, one long hold-off on request
   initial begin : receiver
      int span;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (quiet) begin
            rsp_ready <= 1'b1;
         end else begin
            span = $urandom_range(1, GAP_MAX);
            rsp_ready <= ($urandom_range(0, 2) != 0);
            repeat (span - 1) @(negedge clock);
         end
      end
   end

   // end the run when nothing has moved for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("md5_message_digest: mismatch");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty message
      send_item(8'h00, 1'b0, 1'b1);
      // short message, end mark on its last byte
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // transaction with neither byte nor end mark
      send_item(8'ha5, 1'b0, 1'b0);
      // extreme bytes, then an end mark with no byte
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h5a, 1'b0, 1'b1);
      // one-byte message carrying its own end mark
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b0);

      // result side held off while input keeps coming
      hold_request = 1'b1;
      send_message(3);
      send_message(2);
      drain_results(SETTLE_CYCLES);

      // random messages
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= QUIET_FROM) begin
            quiet = 1'b1;
         end
         sender_idle = !quiet && ($urandom_range(0, 2) != 0);
         send_message(pick_length());
         if (!paused && items_sent >= PAUSE_AT) begin
            paused = 1'b1;
            drain_results(SETTLE_CYCLES);
         end
      end

      drain_results(DRAIN_CYCLES);
      if (fail_count == 0) begin
         $display("md5_message_digest: match");
      end else begin
         $display("md5_message_digest: mismatch");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/md5_pkg.sv
rtl/core/md5_ctrl.sv
rtl/core/md5_dpath.sv
rtl/core/md5_message_digest.sv
tb/md5_message_digest_check.sv
tb/md5_message_digest_test.sv
